/* rtl/core/spc_pkg.sv */
package spc_pkg;
  localparam int MaxTaps = 8192;
  localparam int AddrW = $clog2(MaxTaps);
  localparam int LenW = 14;
  localparam int SampW = 16;
  localparam int AccW = 48;
  localparam logic [LenW-1:0] LenReset = LenW'(MaxTaps);
  localparam logic [AccW-1:0] RoundBias = AccW'(16384);

  typedef enum logic [2:0] {
    ST_CLEAR, ST_IDLE, ST_LOAD, ST_MAC, ST_DRAIN, ST_ROUND, ST_OUT
  } state_e;

  typedef struct packed {
    logic clr_wr;
    logic tap_wr;
    logic hist_wr;
    logic acc_clr;
    logic mac_rd;
    logic rnd;
    logic adv_wp;
  } ctl_t;

  typedef struct packed {
    logic last_addr;
    logic last_tap;
  } sts_t;

  function automatic logic [SampW-1:0] round_sat(input logic signed [AccW-1:0] acc);
    logic signed [AccW-1:0] s;
    logic signed [AccW-16:0] q;
    s = acc + RoundBias;
    q = s[AccW-1:15];
    if (q > 32767) round_sat = 16'h7fff;
    else if (q < -32768) round_sat = 16'h8000;
    else round_sat = q[15:0];
  endfunction
endpackage

/* rtl/core/spc_if.sv */
interface spc_req_if;
  logic valid;
  logic ready;
  logic req_type;
  logic tap_channel;
  logic [12:0] tap_index;
  logic signed [15:0] tap_value;
  logic signed [15:0] left_in;
  logic signed [15:0] right_in;
  modport source(output valid, req_type, tap_channel, tap_index, tap_value, left_in,
                 right_in, input ready);
  modport sink(input valid, req_type, tap_channel, tap_index, tap_value, left_in,
               right_in, output ready);
endinterface

interface spc_res_if;
  logic valid;
  logic ready;
  logic signed [15:0] left_wet;
  logic signed [15:0] right_wet;
  modport source(output valid, left_wet, right_wet, input ready);
  modport sink(input valid, left_wet, right_wet, output ready);
endinterface

interface spc_cfg_if;
  logic valid;
  logic ready;
  logic [13:0] data;
  modport source(output valid, data, input ready);
  modport sink(input valid, data, output ready);
endinterface

/* rtl/core/spc_ram.sv */
module spc_ram #(
  parameter int Width = 16,
  parameter int Depth = 8192
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk_i) begin
    if (we_i) mem[waddr_i] <= wdata_i;
    rdata_o <= mem[raddr_i];
  end
endmodule

/* rtl/core/spc_datapath.sv */
module spc_datapath (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  spc_pkg::ctl_t           ctl_i,
  output spc_pkg::sts_t           sts_o,
  input  logic [13:0]             len_i,
  input  logic                    tap_channel_i,
  input  logic [12:0]             tap_index_i,
  input  logic [15:0]             tap_value_i,
  input  logic [15:0]             left_in_i,
  input  logic [15:0]             right_in_i,
  output logic [15:0]             left_wet_o,
  output logic [15:0]             right_wet_o
);
  import spc_pkg::*;

  logic [AddrW-1:0] wp_q, wp_d, k_q, k_d;
  logic [AddrW-1:0] tap_waddr, tap_raddr, hist_waddr, hist_raddr;
  logic [SampW-1:0] ltap_wd, rtap_wd, lhist_wd, rhist_wd;
  logic [SampW-1:0] ltap, rtap, lhist, rhist;
  logic ltap_we, rtap_we, hist_we;
  logic rd_q, rd2_q;
  logic signed [31:0] lprod_q, rprod_q;
  logic signed [AccW-1:0] lacc_q, racc_q;
  logic [LenW-1:0] len_eff;

  assign len_eff = (len_i > LenReset) ? LenReset : len_i;
  assign sts_o.last_addr = (k_q == AddrW'(MaxTaps - 1));
  assign sts_o.last_tap = ({1'b0, k_q} + 1'b1 >= len_eff);

  assign tap_waddr = ctl_i.clr_wr ? k_q : tap_index_i;
  assign ltap_wd = ctl_i.clr_wr ? '0 : tap_value_i;
  assign rtap_wd = ltap_wd;
  assign ltap_we = ctl_i.clr_wr || (ctl_i.tap_wr && !tap_channel_i);
  assign rtap_we = ctl_i.clr_wr || (ctl_i.tap_wr && tap_channel_i);
  assign hist_we = ctl_i.clr_wr || ctl_i.hist_wr;
  assign hist_waddr = ctl_i.clr_wr ? k_q : wp_q;
  assign lhist_wd = ctl_i.clr_wr ? '0 : left_in_i;
  assign rhist_wd = ctl_i.clr_wr ? '0 : right_in_i;
  assign tap_raddr = k_q;
  assign hist_raddr = wp_q - k_q;

  spc_ram #(.Width(SampW), .Depth(MaxTaps)) u_ltap (.clk_i, .we_i(ltap_we),
    .waddr_i(tap_waddr), .wdata_i(ltap_wd), .raddr_i(tap_raddr), .rdata_o(ltap));
  spc_ram #(.Width(SampW), .Depth(MaxTaps)) u_rtap (.clk_i, .we_i(rtap_we),
    .waddr_i(tap_waddr), .wdata_i(rtap_wd), .raddr_i(tap_raddr), .rdata_o(rtap));
  spc_ram #(.Width(SampW), .Depth(MaxTaps)) u_lhist (.clk_i, .we_i(hist_we),
    .waddr_i(hist_waddr), .wdata_i(lhist_wd), .raddr_i(hist_raddr), .rdata_o(lhist));
  spc_ram #(.Width(SampW), .Depth(MaxTaps)) u_rhist (.clk_i, .we_i(hist_we),
    .waddr_i(hist_waddr), .wdata_i(rhist_wd), .raddr_i(hist_raddr), .rdata_o(rhist));

  always_comb begin
    k_d = k_q;
    wp_d = wp_q;
    if (ctl_i.clr_wr || ctl_i.mac_rd) k_d = k_q + 1'b1;
    if (ctl_i.acc_clr) k_d = '0;
    if (ctl_i.adv_wp) wp_d = wp_q + 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k_q <= '0;
      wp_q <= '0;
      rd_q <= 1'b0;
      rd2_q <= 1'b0;
    end else begin
      k_q <= k_d;
      wp_q <= wp_d;
      rd_q <= ctl_i.mac_rd && ({1'b0, k_q} < len_eff);
      rd2_q <= rd_q;
    end
  end

  always_ff @(posedge clk_i) begin
    lprod_q <= $signed(ltap) * $signed(lhist);
    rprod_q <= $signed(rtap) * $signed(rhist);
    if (ctl_i.acc_clr) begin
      lacc_q <= '0;
      racc_q <= '0;
    end else if (rd2_q) begin
      lacc_q <= lacc_q + AccW'(lprod_q);
      racc_q <= racc_q + AccW'(rprod_q);
    end
    if (ctl_i.rnd) begin
      left_wet_o <= round_sat(lacc_q);
      right_wet_o <= round_sat(racc_q);
    end
  end
endmodule

/* rtl/core/spc_ctrl.sv */
module spc_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  input  logic          in_type_i,
  output logic          in_ready_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  input  spc_pkg::sts_t sts_i,
  output spc_pkg::ctl_t ctl_o
);
  import spc_pkg::*;

  state_e state_q, state_d;
  logic [1:0] drain_q, drain_d;

  always_comb begin
    state_d = state_q;
    drain_d = drain_q;
    case (state_q)
      ST_CLEAR: if (sts_i.last_addr) state_d = ST_IDLE;
      ST_IDLE: begin
        if (in_valid_i) state_d = in_type_i ? ST_IDLE : ST_MAC;
      end
      ST_MAC: begin
        if (sts_i.last_tap) begin
          state_d = ST_DRAIN;
          drain_d = '0;
        end
      end
      ST_DRAIN: begin
        drain_d = drain_q + 1'b1;
        if (drain_q == 2'd2) state_d = ST_ROUND;
      end
      ST_ROUND: state_d = ST_OUT;
      ST_OUT: if (out_ready_i) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    ctl_o = '0;
    in_ready_o = 1'b0;
    out_valid_o = 1'b0;
    case (state_q)
      ST_CLEAR: ctl_o.clr_wr = 1'b1;
      ST_IDLE: begin
        in_ready_o = 1'b1;
        ctl_o.tap_wr = in_valid_i && in_type_i;
        ctl_o.hist_wr = in_valid_i && !in_type_i;
        ctl_o.acc_clr = 1'b1;
      end
      ST_MAC: ctl_o.mac_rd = 1'b1;
      ST_ROUND: ctl_o.rnd = 1'b1;
      ST_OUT: begin
        out_valid_o = 1'b1;
        ctl_o.adv_wp = out_ready_i;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      drain_q <= '0;
    end else begin
      state_q <= state_d;
      drain_q <= drain_d;
    end
  end

  a_no_ready_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> !out_valid_o) else $error("ready while result pending");
  a_mac_one_hot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({ctl_o.clr_wr, ctl_o.mac_rd, ctl_o.hist_wr})) else $error("ram conflict");
  a_round_then_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_o.rnd |=> out_valid_o) else $error("result missing");
endmodule

/* rtl/core/stereo_partitioned_convolver.sv */
// Channel   Dir  Contents
// req_if    in   req_type, tap_channel, tap_index, tap_value, left_in, right_in
// res_if    out  left_wet, right_wet
// cfg_if    in   active_length
// A tap load is written directly while idle; a sample is convolved over L = min(active_length, 8192) taps,
// by one multiply-accumulate per tap per channel over the tap and history memories.
// After reset a clearing pass zeroes all memories before any word is taken.
// The result word holds until taken; no new word is accepted meanwhile.
module stereo_partitioned_convolver (
  input logic clk_i,
  input logic rst_ni,
  spc_req_if.sink req_if,
  spc_res_if.source res_if,
  spc_cfg_if.sink cfg_if
);
  import spc_pkg::*;

  ctl_t ctl;
  sts_t sts;
  logic [LenW-1:0] len_q;

  assign cfg_if.ready = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) len_q <= LenReset;
    else if (cfg_if.valid) len_q <= cfg_if.data;
  end

  spc_ctrl u_ctrl (.clk_i, .rst_ni, .in_valid_i(req_if.valid), .in_type_i(req_if.req_type),
    .in_ready_o(req_if.ready), .out_valid_o(res_if.valid), .out_ready_i(res_if.ready),
    .sts_i(sts), .ctl_o(ctl));

  spc_datapath u_dp (.clk_i, .rst_ni, .ctl_i(ctl), .sts_o(sts), .len_i(len_q),
    .tap_channel_i(req_if.tap_channel), .tap_index_i(req_if.tap_index),
    .tap_value_i(req_if.tap_value), .left_in_i(req_if.left_in),
    .right_in_i(req_if.right_in), .left_wet_o(res_if.left_wet),
    .right_wet_o(res_if.right_wet));
endmodule

/* tb/tb_stereo_partitioned_convolver.sv */
module tb_stereo_partitioned_convolver;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int Taps = spc_pkg::MaxTaps;
  localparam int IdleLimit = 50000;
  localparam int SettleCycles = 20;

  typedef struct {
    bit req_type;
    bit tap_channel;
    bit [12:0] tap_index;
    logic signed [15:0] tap_value;
    logic signed [15:0] left_in;
    logic signed [15:0] right_in;
    bit has_wet;
    logic signed [15:0] left_wet;
    logic signed [15:0] right_wet;
  } word_t;

  typedef struct {
    logic signed [15:0] left_wet;
    logic signed [15:0] right_wet;
  } wet_t;

  logic clk_i;
  logic rst_ni;

  spc_req_if req_if ();
  spc_res_if res_if ();
  spc_cfg_if cfg_if ();

  stereo_partitioned_convolver u_dut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .req_if(req_if),
    .res_if(res_if),
    .cfg_if(cfg_if)
  );

  logic signed [15:0] left_taps [Taps];
  logic signed [15:0] right_taps [Taps];
  logic signed [15:0] left_hist [Taps];
  logic signed [15:0] right_hist [Taps];
  int unsigned hist_pos;
  int unsigned tap_count;

  wet_t wet_queue [$];
  int errors;
  int wet_seen;
  bit send_burst;
  bit take_burst;

  word_t directed [] = '{
    '{0, 0, 13'd0, 16'sh0000, 16'sh7fff, -16'sh8000, 1, 16'sh0000, 16'sh0000},
    '{1, 0, 13'd0, -16'sh8000, 16'sh0000, 16'sh0000, 0, 0, 0},
    '{1, 0, 13'd1, -16'sh8000, 16'sh0000, 16'sh0000, 0, 0, 0},
    '{1, 1, 13'd0, 16'sh7fff, 16'sh0000, 16'sh0000, 0, 0, 0},
    '{1, 1, 13'd1, 16'sh7fff, 16'sh0000, 16'sh0000, 0, 0, 0},
    '{0, 0, 13'd0, 16'sh0000, -16'sh8000, -16'sh8000, 0, 0, 0},
    '{0, 0, 13'd0, 16'sh0000, -16'sh8000, -16'sh8000, 1, 16'sh7fff, -16'sh8000},
    '{1, 0, 13'd8191, 16'sh5555, 16'sh7fff, -16'sh8000, 0, 0, 0},
    '{1, 1, 13'd4096, -16'sh5556, 16'sh1234, 16'sh4321, 0, 0, 0},
    '{1, 0, 13'h1555, 16'sh2aaa, 16'sh0000, 16'sh0000, 0, 0, 0},
    '{1, 1, 13'h0aaa, -16'sh2aab, 16'sh0000, 16'sh0000, 0, 0, 0},
    '{0, 1, 13'h1fff, -16'sh1, 16'sh0000, 16'sh0000, 0, 0, 0},
    '{0, 0, 13'd0, 16'sh0000, 16'sh5555, -16'sh5556, 0, 0, 0},
    '{1, 1, 13'd2, 16'sh4000, -16'sh1, 16'sh1, 0, 0, 0},
    '{0, 0, 13'd0, 16'sh0000, -16'sh5556, 16'sh5555, 0, 0, 0}
  };

  int unsigned lengths [] = '{1, 0, 37, 16383, 5, 128, 2, 64, 8192, 20, 3, 1000};

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic logic signed [15:0] round_to_q15(input longint acc);
    longint q;
    q = (acc + 16384) >>> 15;
    if (q > 32767) return 16'sh7fff;
    if (q < -32768) return -16'sh8000;
    return q[15:0];
  endfunction

  function automatic wet_t convolve_sample(input logic signed [15:0] l, input logic signed [15:0] r);
    wet_t w;
    longint acc_l;
    longint acc_r;
    int unsigned n;
    int unsigned pos;
    left_hist[hist_pos] = l;
    right_hist[hist_pos] = r;
    n = (tap_count > Taps) ? Taps : tap_count;
    acc_l = 0;
    acc_r = 0;
    pos = hist_pos;
    for (int unsigned k = 0; k < n; k++) begin
      acc_l += longint'(left_taps[k]) * longint'(left_hist[pos]);
      acc_r += longint'(right_taps[k]) * longint'(right_hist[pos]);
      pos = (pos == 0) ? Taps - 1 : pos - 1;
    end
    w.left_wet = round_to_q15(acc_l);
    w.right_wet = round_to_q15(acc_r);
    hist_pos = (hist_pos + 1) % Taps;
    return w;
  endfunction

  task automatic report(input string what, input int got, input int want);
    errors++;
    $display("mismatch at word %0d: %s got %0d expected %0d", wet_seen, what, got, want);
  endtask

  task automatic send_word(input word_t w);
    int gap;
    wet_t p;
    if ($urandom_range(0, 19) == 0) send_burst = ~send_burst;
    gap = send_burst ? 0 : $urandom_range(0, 15);
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_if.valid <= 1'b1;
    req_if.req_type <= w.req_type;
    req_if.tap_channel <= w.tap_channel;
    req_if.tap_index <= w.tap_index;
    req_if.tap_value <= w.tap_value;
    req_if.left_in <= w.left_in;
    req_if.right_in <= w.right_in;
    do @(posedge clk_i); while (!req_if.ready);
    if (w.req_type) begin
      if (w.tap_channel) right_taps[w.tap_index] = w.tap_value;
      else left_taps[w.tap_index] = w.tap_value;
    end else begin
      p = convolve_sample(w.left_in, w.right_in);
      if (w.has_wet) begin
        p.left_wet = w.left_wet;
        p.right_wet = w.right_wet;
      end
      wet_queue.push_back(p);
    end
  endtask

  task automatic write_length(input int unsigned len);
    req_if.valid <= 1'b0;
    while (wet_queue.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
    cfg_if.valid <= 1'b1;
    cfg_if.data <= len[13:0];
    do @(posedge clk_i); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    tap_count = len;
  endtask

  function automatic word_t random_word();
    word_t w;
    w.req_type = ($urandom_range(0, 99) < 35);
    w.tap_channel = 1'($urandom_range(0, 1));
    w.tap_index = ($urandom_range(0, 9) < 7) ? 13'($urandom_range(0, 63))
                                             : 13'($urandom_range(0, 8191));
    w.tap_value = 16'($urandom());
    w.left_in = ($urandom_range(0, 9) == 0) ? ($urandom_range(0, 1) ? 16'sh7fff : -16'sh8000)
                                           : 16'($urandom());
    w.right_in = ($urandom_range(0, 9) == 0) ? ($urandom_range(0, 1) ? 16'sh7fff : -16'sh8000)
                                            : 16'($urandom());
    w.has_wet = 0;
    return w;
  endfunction

  initial begin
    int gap;
    wet_t e;
    res_if.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      if ($urandom_range(0, 19) == 0) take_burst = ~take_burst;
      gap = take_burst ? 0 : $urandom_range(0, 15);
      if (wet_seen == 30) gap = 400;
      if (gap > 0) begin
        res_if.ready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      res_if.ready <= 1'b1;
      do @(posedge clk_i); while (!res_if.valid);
      if (wet_queue.size() == 0) begin
        report("unexpected left_wet", res_if.left_wet, 0);
      end else begin
        e = wet_queue.pop_front();
        if (res_if.left_wet !== e.left_wet) report("left_wet", res_if.left_wet, e.left_wet);
        if (res_if.right_wet !== e.right_wet) report("right_wet", res_if.right_wet, e.right_wet);
      end
      wet_seen++;
    end
  end

  initial begin
    int idle;
    idle = 0;
    forever begin
      @(posedge clk_i);
      if ((req_if.valid && req_if.ready) || (res_if.valid && res_if.ready) ||
          (cfg_if.valid && cfg_if.ready)) idle = 0;
      else idle++;
      if (idle >= IdleLimit) begin
        $display("tb_stereo_partitioned_convolver NOT OK");
        $finish;
      end
    end
  end

  initial begin
    int n;
    errors = 0;
    wet_seen = 0;
    hist_pos = 0;
    tap_count = Taps;
    send_burst = 0;
    take_burst = 0;
    for (int i = 0; i < Taps; i++) begin
      left_taps[i] = 0;
      right_taps[i] = 0;
      left_hist[i] = 0;
      right_hist[i] = 0;
    end
    req_if.valid = 1'b0;
    req_if.req_type = 1'b0;
    req_if.tap_channel = 1'b0;
    req_if.tap_index = '0;
    req_if.tap_value = '0;
    req_if.left_in = '0;
    req_if.right_in = '0;
    cfg_if.valid = 1'b0;
    cfg_if.data = '0;
    rst_ni = 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed[i]) send_word(directed[i]);

    foreach (lengths[p]) begin
      write_length(lengths[p]);
      n = (lengths[p] >= 1000) ? 4 : 30;
      for (int i = 0; i < n; i++) send_word(random_word());
    end

    req_if.valid <= 1'b0;
    while (wet_queue.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
    if (errors == 0) $display("tb_stereo_partitioned_convolver OK");
    else $display("tb_stereo_partitioned_convolver NOT OK");
    $finish;
  end
endmodule

/* sim.f */
rtl/core/spc_pkg.sv
rtl/core/spc_if.sv
rtl/core/spc_ram.sv
rtl/core/spc_datapath.sv
rtl/core/spc_ctrl.sv
rtl/core/stereo_partitioned_convolver.sv
tb/tb_stereo_partitioned_convolver.sv
